// ----- src/pspr_pkg.sv -----
// Shared constants, codes and control types for the path slot pool.
`timescale 1ns / 1ps
package pspr_pkg;

   localparam int POOL_SLOTS     = 256;
   localparam int SLOT_W         = $clog2(POOL_SLOTS);
   localparam int TILES_PER_SLOT = 64;
   localparam int TIDX_W         = $clog2(TILES_PER_SLOT);
   localparam int LEN_W          = $clog2(TILES_PER_SLOT + 1);
   localparam int TADDR_W        = SLOT_W + TIDX_W;
   localparam int OWNERS         = 256;
   localparam int OWN_W          = $clog2(OWNERS);
   localparam int RING_DEPTH     = 4;
   localparam int RIDX_W         = $clog2(RING_DEPTH);
   localparam int RCNT_W         = $clog2(RING_DEPTH + 1);
   localparam int RADDR_W        = OWN_W + RIDX_W;
   localparam int META_W         = RIDX_W + RCNT_W;
   localparam int GRP_SIZE       = 16;
   localparam int GRP_W          = $clog2(GRP_SIZE);
   localparam int GRPS           = POOL_SLOTS / GRP_SIZE;
   localparam int GSEL_W         = $clog2(GRPS);
   localparam int OP_W           = 4;
   localparam int VAL_W          = 16;
   localparam int REQ_DATA_W     = 56;
   localparam int RSP_DATA_W     = 32;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR      = 4'd0,
      OP_ACQUIRE    = 4'd1,
      OP_RELEASE    = 4'd2,
      OP_CLR_TILES  = 4'd3,
      OP_APPEND     = 4'd4,
      OP_READ_TILES = 4'd5,
      OP_READ_KIND  = 4'd6,
      OP_DUPLICATE  = 4'd7,
      OP_PUSH       = 4'd8,
      OP_PATH_AT    = 4'd9,
      OP_OWN_CLEAR  = 4'd10
   } op_type;

   typedef enum logic [17:0] {
      S_IDLE     = 18'h00001,
      S_LOOK     = 18'h00002,
      S_DEC      = 18'h00004,
      S_FIND     = 18'h00008,
      S_APP_RD   = 18'h00010,
      S_APP_CHK  = 18'h00020,
      S_RD_ADDR  = 18'h00040,
      S_RD_OUT   = 18'h00080,
      S_CP_RD    = 18'h00100,
      S_CP_WR    = 18'h00200,
      S_PUSH_RD  = 18'h00400,
      S_PUSH_WR  = 18'h00800,
      S_PA_RD    = 18'h01000,
      S_PA_LEN   = 18'h02000,
      S_PA_CNT   = 18'h04000,
      S_CLR_RD   = 18'h08000,
      S_CLR_FREE = 18'h10000,
      S_CLR_END  = 18'h20000
   } state_type;

   typedef struct packed {
      logic      take;
      logic      emit_final;
      state_type st;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   live;
      logic   len_nz;
      logic   own_ok;
      logic   id_nz;
      logic   ring_full;
      logic   ri_ok;
      logic   cnt_nz;
      logic   found;
      logic   last_tile;
      logic   last_ring;
      logic   rsp_free;
   } dp_sts_type;

endpackage

// ----- src/pspr_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pspr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/pspr_ctrl.sv -----
// Command sequencer for the path slot pool.
`timescale 1ns / 1ps
module pspr_ctrl
   import pspr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      emit_final_ff, emit_final_in;

   always_comb begin
      state_in      = state_ff;
      emit_final_in = emit_final_ff;
      unique case (state_ff)
         S_IDLE: begin
            emit_final_in = 1'b0;
            if (req_tvalid && !emit_final_ff) state_in = S_LOOK;
         end
         S_LOOK:    state_in = S_DEC;
         S_DEC: begin
            state_in      = S_IDLE;
            emit_final_in = 1'b1;
            case (sts.op)
               OP_ACQUIRE: begin
                  state_in      = S_FIND;
                  emit_final_in = 1'b0;
               end
               OP_APPEND: if (sts.live) begin
                  state_in      = S_APP_RD;
                  emit_final_in = 1'b0;
               end
               OP_READ_TILES: if (sts.live && sts.len_nz) begin
                  state_in      = S_RD_ADDR;
                  emit_final_in = 1'b0;
               end
               OP_DUPLICATE: if (sts.live) begin
                  state_in      = S_FIND;
                  emit_final_in = 1'b0;
               end
               OP_PUSH: if (sts.own_ok && sts.id_nz) begin
                  state_in      = sts.ring_full ? S_PUSH_RD : S_PUSH_WR;
                  emit_final_in = 1'b0;
               end
               OP_PATH_AT: if (sts.own_ok && sts.ri_ok) begin
                  state_in      = S_PA_RD;
                  emit_final_in = 1'b0;
               end
               OP_OWN_CLEAR: if (sts.own_ok) begin
                  state_in      = sts.cnt_nz ? S_CLR_RD : S_CLR_END;
                  emit_final_in = 1'b0;
               end
               default: ;
            endcase
         end
         S_FIND: begin
            if (sts.op == OP_DUPLICATE && sts.found && sts.len_nz) begin
               state_in = S_CP_RD;
            end else begin
               state_in      = S_IDLE;
               emit_final_in = 1'b1;
            end
         end
         S_APP_RD:  state_in = S_APP_CHK;
         S_APP_CHK: begin
            state_in      = S_IDLE;
            emit_final_in = 1'b1;
         end
         S_RD_ADDR: state_in = S_RD_OUT;
         S_RD_OUT: if (sts.rsp_free) state_in = sts.last_tile ? S_IDLE : S_RD_ADDR;
         S_CP_RD:   state_in = S_CP_WR;
         S_CP_WR: begin
            if (sts.last_tile) begin
               state_in      = S_IDLE;
               emit_final_in = 1'b1;
            end else begin
               state_in = S_CP_RD;
            end
         end
         S_PUSH_RD: state_in = S_PUSH_WR;
         S_PUSH_WR: begin
            state_in      = S_IDLE;
            emit_final_in = 1'b1;
         end
         S_PA_RD:   state_in = S_PA_LEN;
         S_PA_LEN:  state_in = S_PA_CNT;
         S_PA_CNT: begin
            state_in      = S_IDLE;
            emit_final_in = 1'b1;
         end
         S_CLR_RD:  state_in = S_CLR_FREE;
         S_CLR_FREE: state_in = sts.last_ring ? S_CLR_END : S_CLR_RD;
         S_CLR_END: begin
            state_in      = S_IDLE;
            emit_final_in = 1'b1;
         end
         default:   state_in = S_IDLE;
      endcase
      if (emit_final_ff && !sts.rsp_free) begin
         state_in      = state_ff;
         emit_final_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         emit_final_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         emit_final_ff <= emit_final_in;
      end
   end

   assign req_tready     = (state_ff == S_IDLE) && !emit_final_ff;
   assign cmd.take       = req_tready && req_tvalid;
   assign cmd.emit_final = emit_final_ff;
   assign cmd.st         = emit_final_ff ? S_IDLE : state_ff;

endmodule

// ----- src/pspr_dp.sv -----
// Slot tables, tile store, owner rings and result register.
`timescale 1ns / 1ps
module pspr_dp
   import pspr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [OWN_W-1:0]  req_owner,
   input  logic [RIDX_W-1:0] req_ring_index,
   input  logic [VAL_W-1:0]  req_tile,
   input  logic [VAL_W-1:0]  req_kind,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [SLOT_W-1:0] rsp_result_slot,
   output logic [VAL_W-1:0]  rsp_value,
   output logic [LEN_W-1:0]  rsp_tile_count,
   output logic              rsp_valid_res,
   output logic              rsp_last
);

   op_type            op_ff;
   logic [SLOT_W-1:0] id_ff, new_ff, res_slot_ff, rsp_slot_ff;
   logic [OWN_W-1:0]  own_ff;
   logic [RIDX_W-1:0] ri_ff, head_ff;
   logic [VAL_W-1:0]  tile_ff, kind_ff, kind_id_ff, res_val_ff, rsp_val_ff;
   logic [LEN_W-1:0]  n_ff, i_ff, res_cnt_ff, rsp_cnt_ff;
   logic [RCNT_W-1:0] cnt_ff;
   logic              res_vld_ff, res_use_id_ff, rsp_vld_ff, rsp_last_ff, rsp_valid_ff;
   logic [POOL_SLOTS-1:0] used_ff;
   logic [OWNERS-1:0]     meta_vld_ff;
   logic [GRPS-1:0]       grp_any_ff;
   logic [GRP_W-1:0]      grp_idx_ff [GRPS];

   logic [VAL_W-1:0]  kind_rd, tile_rd, kind_wr_data, tile_wr_data;
   logic [LEN_W-1:0]  len_rd, len_wr_data, len_eff;
   logic [SLOT_W-1:0] ring_rd, len_rd_addr, len_wr_addr, pick_slot;
   logic [META_W-1:0] meta_rd, meta_eff, meta_wr_data;
   logic [RIDX_W-1:0] head_eff, ring_idx, ring_wr_idx;
   logic [RCNT_W-1:0] cnt_eff;
   logic [TADDR_W-1:0] tile_rd_addr, tile_wr_addr;
   logic [POOL_SLOTS-1:0] slot_free;
   logic [GRPS-1:0]       grp_any;
   logic [GRP_W-1:0]      grp_idx [GRPS];
   logic id_live, found, app_ok, ring_full_q, rsp_free, emit_tile, emit;
   logic len_rd_en, len_wr_en, tile_rd_en, tile_wr_en, ring_rd_en, kind_wr_en;

   assign id_live  = (id_ff != '0) && used_ff[id_ff];
   assign len_eff  = id_live ? len_rd : '0;
   assign meta_eff = meta_vld_ff[own_ff] ? meta_rd : '0;
   assign head_eff = meta_eff[META_W-1:RCNT_W];
   assign cnt_eff  = meta_eff[RCNT_W-1:0];
   assign ring_full_q = (cnt_ff == RCNT_W'(RING_DEPTH));
   assign app_ok   = ((n_ff == '0) || (tile_rd != tile_ff))
                     && (n_ff < LEN_W'(TILES_PER_SLOT));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign emit_tile = (cmd.st == S_RD_OUT) && rsp_free;
   assign emit      = emit_tile || (cmd.emit_final && rsp_free);

   always_comb begin
      slot_free    = ~used_ff;
      slot_free[0] = 1'b0;
      for (int g = 0; g < GRPS; g++) begin
         grp_any[g] = 1'b0;
         grp_idx[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (slot_free[g*GRP_SIZE + b]) begin
               grp_any[g] = 1'b1;
               grp_idx[g] = GRP_W'(b);
            end
         end
      end
   end

   always_comb begin
      found     = 1'b0;
      pick_slot = '0;
      for (int g = GRPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found     = 1'b1;
            pick_slot = {GSEL_W'(g), grp_idx_ff[g]};
         end
      end
   end

   always_comb begin
      len_rd_en    = (cmd.st == S_LOOK) || (cmd.st == S_PA_LEN);
      len_rd_addr  = (cmd.st == S_PA_LEN) ? ring_rd : id_ff;
      len_wr_en    = 1'b0;
      len_wr_addr  = id_ff;
      len_wr_data  = '0;
      kind_wr_en   = (cmd.st == S_FIND) && found;
      kind_wr_data = (op_ff == OP_ACQUIRE) ? kind_ff : kind_id_ff;
      tile_rd_en   = (cmd.st == S_APP_RD) || (cmd.st == S_RD_ADDR) || (cmd.st == S_CP_RD);
      tile_rd_addr = {id_ff, i_ff[TIDX_W-1:0]};
      tile_wr_en   = 1'b0;
      tile_wr_addr = {new_ff, i_ff[TIDX_W-1:0]};
      tile_wr_data = tile_rd;
      ring_rd_en   = (cmd.st == S_PUSH_RD) || (cmd.st == S_PA_RD) || (cmd.st == S_CLR_RD);
      ring_idx     = RIDX_W'(head_ff + RIDX_W'(i_ff));
      ring_wr_idx  = ring_full_q ? head_ff : RIDX_W'(head_ff + RIDX_W'(cnt_ff));
      meta_wr_data = ring_full_q ? {RIDX_W'(head_ff + 1'b1), cnt_ff}
                                 : {head_ff, RCNT_W'(cnt_ff + 1'b1)};
      case (cmd.st)
         S_DEC: begin
            len_wr_en = (op_ff == OP_CLR_TILES) && id_live;
         end
         S_FIND: begin
            len_wr_en   = found;
            len_wr_addr = pick_slot;
            len_wr_data = (op_ff == OP_ACQUIRE) ? '0 : n_ff;
         end
         S_APP_RD: begin
            tile_rd_addr = {id_ff, TIDX_W'(n_ff - 1'b1)};
         end
         S_APP_CHK: begin
            len_wr_en    = app_ok;
            len_wr_data  = LEN_W'(n_ff + 1'b1);
            tile_wr_en   = app_ok;
            tile_wr_addr = {id_ff, n_ff[TIDX_W-1:0]};
            tile_wr_data = tile_ff;
         end
         S_CP_WR:   tile_wr_en = 1'b1;
         S_PUSH_RD: ring_idx = head_ff;
         S_PA_RD:   ring_idx = RIDX_W'(head_ff + RIDX_W'(cnt_ff) - 1'b1 - ri_ff);
         default: ;
      endcase
   end

   pspr_ram #(.WIDTH(VAL_W), .DEPTH(POOL_SLOTS)) u_kind_ram (
      .clock(clock), .wr_en(kind_wr_en), .wr_addr(pick_slot), .wr_data(kind_wr_data),
      .rd_en(cmd.st == S_LOOK), .rd_addr(id_ff), .rd_data(kind_rd)
   );

   pspr_ram #(.WIDTH(LEN_W), .DEPTH(POOL_SLOTS)) u_len_ram (
      .clock(clock), .wr_en(len_wr_en), .wr_addr(len_wr_addr), .wr_data(len_wr_data),
      .rd_en(len_rd_en), .rd_addr(len_rd_addr), .rd_data(len_rd)
   );

   pspr_ram #(.WIDTH(VAL_W), .DEPTH(POOL_SLOTS * TILES_PER_SLOT)) u_tile_ram (
      .clock(clock), .wr_en(tile_wr_en), .wr_addr(tile_wr_addr), .wr_data(tile_wr_data),
      .rd_en(tile_rd_en), .rd_addr(tile_rd_addr), .rd_data(tile_rd)
   );

   pspr_ram #(.WIDTH(SLOT_W), .DEPTH(OWNERS * RING_DEPTH)) u_ring_ram (
      .clock(clock), .wr_en(cmd.st == S_PUSH_WR), .wr_addr({own_ff, ring_wr_idx}),
      .wr_data(id_ff), .rd_en(ring_rd_en), .rd_addr({own_ff, ring_idx}), .rd_data(ring_rd)
   );

   pspr_ram #(.WIDTH(META_W), .DEPTH(OWNERS)) u_meta_ram (
      .clock(clock), .wr_en(cmd.st == S_PUSH_WR), .wr_addr(own_ff), .wr_data(meta_wr_data),
      .rd_en(cmd.st == S_LOOK), .rd_addr(own_ff), .rd_data(meta_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         meta_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.st)
            S_DEC: begin
               if (op_ff == OP_CLEAR) begin
                  used_ff     <= '0;
                  meta_vld_ff <= '0;
               end else if (op_ff == OP_RELEASE && id_ff != '0) begin
                  used_ff[id_ff] <= 1'b0;
               end
            end
            S_FIND: if (found) used_ff[pick_slot] <= 1'b1;
            S_PUSH_WR: begin
               if (ring_full_q && ring_rd != '0) used_ff[ring_rd] <= 1'b0;
               meta_vld_ff[own_ff] <= 1'b1;
            end
            S_CLR_FREE: if (ring_rd != '0) used_ff[ring_rd] <= 1'b0;
            S_CLR_END:  meta_vld_ff[own_ff] <= 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any;
      grp_idx_ff <= grp_idx;
      if (cmd.take) begin
         op_ff   <= op_type'(req_opcode);
         id_ff   <= req_slot;
         own_ff  <= req_owner;
         ri_ff   <= req_ring_index;
         tile_ff <= req_tile;
         kind_ff <= req_kind;
      end
      case (cmd.st)
         S_DEC: begin
            n_ff          <= len_eff;
            kind_id_ff    <= kind_rd;
            head_ff       <= head_eff;
            cnt_ff        <= cnt_eff;
            i_ff          <= '0;
            res_slot_ff   <= '0;
            res_val_ff    <= '0;
            res_cnt_ff    <= '0;
            res_vld_ff    <= 1'b0;
            res_use_id_ff <= (op_ff == OP_PUSH) || (op_ff == OP_OWN_CLEAR);
            if (op_ff == OP_READ_KIND && id_live) begin
               res_val_ff <= kind_rd;
               res_cnt_ff <= len_rd;
               res_vld_ff <= 1'b1;
            end
         end
         S_FIND: if (found) begin
            res_slot_ff <= pick_slot;
            res_cnt_ff  <= (op_ff == OP_ACQUIRE) ? '0 : n_ff;
            new_ff      <= pick_slot;
         end
         S_APP_CHK:  res_cnt_ff <= app_ok ? LEN_W'(n_ff + 1'b1) : n_ff;
         S_RD_OUT:   if (rsp_free) i_ff <= LEN_W'(i_ff + 1'b1);
         S_CP_WR:    i_ff <= LEN_W'(i_ff + 1'b1);
         S_CLR_FREE: i_ff <= LEN_W'(i_ff + 1'b1);
         S_PA_LEN:   res_slot_ff <= ring_rd;
         S_PA_CNT: begin
            res_cnt_ff <= (res_slot_ff != '0 && used_ff[res_slot_ff]) ? len_rd : '0;
         end
         default: ;
      endcase
      if (emit_tile) begin
         rsp_slot_ff <= '0;
         rsp_val_ff  <= tile_rd;
         rsp_cnt_ff  <= n_ff;
         rsp_vld_ff  <= 1'b1;
         rsp_last_ff <= sts.last_tile;
      end else if (emit) begin
         rsp_slot_ff <= res_slot_ff;
         rsp_val_ff  <= res_val_ff;
         rsp_cnt_ff  <= res_use_id_ff ? (id_live ? n_ff : '0) : res_cnt_ff;
         rsp_vld_ff  <= res_vld_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign sts.op        = op_ff;
   assign sts.live      = id_live;
   assign sts.len_nz    = (cmd.st == S_DEC) ? (len_eff != '0) : (n_ff != '0);
   assign sts.own_ok    = own_ff != '0;
   assign sts.id_nz     = id_ff != '0;
   assign sts.ring_full = cnt_eff == RCNT_W'(RING_DEPTH);
   assign sts.ri_ok     = RCNT_W'(ri_ff) < cnt_eff;
   assign sts.cnt_nz    = cnt_eff != '0;
   assign sts.found     = found;
   assign sts.last_tile = i_ff == LEN_W'(n_ff - 1'b1);
   assign sts.last_ring = i_ff == LEN_W'(cnt_ff - 1'b1);
   assign sts.rsp_free  = rsp_free;

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_value       = rsp_val_ff;
   assign rsp_tile_count  = rsp_cnt_ff;
   assign rsp_valid_res   = rsp_vld_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- src/path_slot_pool_with_owner_rings_unit.sv -----
// Path slot pool with per-owner rings: top level.
// Tile read answers with one response item per stored tile, the last one marked by tlast.
// Duplicate copies the tiles of the source slot into the newly picked slot one tile at a time.
// Owner clear walks the ring and frees each entry's slot; push into a full ring frees the oldest entry's slot.
// One command at a time; the result register decouples.
// Synchronous reset clears used flags and ring heads/counts at once.
`timescale 1ns / 1ps
module path_slot_pool_with_owner_rings_unit
   import pspr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // slot[7:0], owner[15:8], ring_index[17:16], tile[33:18], kind[49:34]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[3:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_slot[7:0], value[23:8], tile_count[30:24]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // valid_res
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic [SLOT_W-1:0] rsp_result_slot;
   logic [VAL_W-1:0]  rsp_value;
   logic [LEN_W-1:0]  rsp_tile_count;

   pspr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .sts(sts), .cmd(cmd)
   );

   pspr_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_opcode(req_tuser),
      .req_slot(req_tdata[7:0]),
      .req_owner(req_tdata[15:8]),
      .req_ring_index(req_tdata[17:16]),
      .req_tile(req_tdata[33:18]),
      .req_kind(req_tdata[49:34]),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_result_slot(rsp_result_slot),
      .rsp_value(rsp_value),
      .rsp_tile_count(rsp_tile_count),
      .rsp_valid_res(rsp_tuser),
      .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_tile_count, rsp_value, rsp_result_slot};

endmodule

// ----- src/pspr_chk.sv -----
// Port-level checks for the path slot pool top level.
`timescale 1ns / 1ps
module pspr_chk
   import pspr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   a_plain_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[23:8] == 16'd0)
      else $error("result without value is not a lone final item");

   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("item taken in the middle of a tile run");

endmodule

bind path_slot_pool_with_owner_rings_unit pspr_chk u_pspr_chk (.*);
